// ----- sv/brd_pkg.sv -----
// shared types and constants for the bit vector rank dictionary
// no dependencies; used by brd_popadd, brd_store and bitvector_rank_dictionary

package brd_pkg;

	localparam int WORD_BITS    = 32;
	localparam int BIT_POS_W    = 5;
	localparam int IDX_W        = 10;
	localparam int LEN_W        = 11;
	localparam int POP_W        = 6;
	localparam int MAX_BITS_DEF = 1024;
	localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

	typedef enum logic [1:0] {
		OP_SET    = 2'd0,
		OP_BUILD  = 2'd1,
		OP_ACCESS = 2'd2,
		OP_RANK   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_FIN,
		ST_BUILD_RD,
		ST_BUILD_WR
	} brd_state_t;

	typedef struct packed {
		logic word_we;
		logic sum_we;
	} brd_store_ctrl_t;

endpackage

// ----- sv/brd_popadd.sv -----
// shared count unit: optional low-bit mask, 32-bit popcount tree, add to a base
// depends on brd_pkg

module brd_popadd (
	input  logic [brd_pkg::WORD_BITS-1:0] word,
	input  logic                          mask_en,
	input  logic [brd_pkg::BIT_POS_W-1:0] bit_pos,
	input  logic [brd_pkg::LEN_W-1:0]     base,
	output logic [brd_pkg::LEN_W-1:0]     sum
);

	logic [brd_pkg::WORD_BITS-1:0] masked;
	logic [1:0] lvl1 [16];
	logic [2:0] lvl2 [8];
	logic [3:0] lvl3 [4];
	logic [4:0] lvl4 [2];
	logic [brd_pkg::POP_W-1:0] pop;

	// keep only bits strictly below bit_pos when masking
	assign masked = mask_en ? (word & ~({brd_pkg::WORD_BITS{1'b1}} << bit_pos)) : word;

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			lvl1[i] = {1'b0, masked[2*i]} + {1'b0, masked[2*i+1]};
		end
		for (int i = 0; i < 8; i++) begin
			lvl2[i] = {1'b0, lvl1[2*i]} + {1'b0, lvl1[2*i+1]};
		end
		for (int i = 0; i < 4; i++) begin
			lvl3[i] = {1'b0, lvl2[2*i]} + {1'b0, lvl2[2*i+1]};
		end
		for (int i = 0; i < 2; i++) begin
			lvl4[i] = {1'b0, lvl3[2*i]} + {1'b0, lvl3[2*i+1]};
		end
		pop = {1'b0, lvl4[0]} + {1'b0, lvl4[1]};
	end

	assign sum = base + brd_pkg::LEN_W'(pop);

endmodule

// ----- sv/brd_store.sv -----
// word memory and prefix sum memory, one write and one registered read each
// depends on brd_pkg

module brd_store #(
	parameter int WORD_COUNT = brd_pkg::MAX_BITS_DEF / brd_pkg::WORD_BITS,
	parameter int WAW        = 5
) (
	input  logic                          clk,
	input  brd_pkg::brd_store_ctrl_t      ctrl,
	input  logic [WAW-1:0]                wr_addr,
	input  logic [WAW-1:0]                rd_addr,
	input  logic [brd_pkg::WORD_BITS-1:0] word_wdata,
	input  logic [brd_pkg::LEN_W-1:0]     sum_wdata,
	output logic [brd_pkg::WORD_BITS-1:0] word_rdata,
	output logic [brd_pkg::LEN_W-1:0]     sum_rdata
);

	logic [brd_pkg::WORD_BITS-1:0] word_mem [WORD_COUNT];
	logic [brd_pkg::LEN_W-1:0]     sum_mem  [WORD_COUNT];

	always_ff @(posedge clk) begin
		if (ctrl.word_we) begin
			word_mem[wr_addr] <= word_wdata;
		end
		word_rdata <= word_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ctrl.sum_we) begin
			sum_mem[wr_addr] <= sum_wdata;
		end
		sum_rdata <= sum_mem[rd_addr];
	end

endmodule

// ----- sv/bitvector_rank_dictionary.sv -----
// top level of the bit vector rank dictionary: sequencer, request latch, result register
// depends on brd_pkg, brd_store and brd_popadd

// A bit vector of MAX_BITS bits kept as 32-bit words, each with a stored count
// of the ones in all lower words. Requests: set (mark one bit), build (recompute
// every prefix count), access (read one bit) and rank (ones or zeros strictly
// below an index, from the stored prefix count plus a masked popcount of the
// word). Prefix counts only change on build, so rank after set and before build
// sees the old counts. An index not below bit_length or MAX_BITS flags
// index_error and changes nothing. One request is handled at a time; in_ready is
// low while it runs. Set, access and rank pass through a memory read state, a state
// through the shared popcount/add unit and a state that loads the result register,
// which waits while the last result is not yet taken; a bad index goes straight to
// the result register state; build walks the words through the same unit, reading
// each word and then writing its prefix count. After reset a clearing pass zeroes
// both memories before the first request is taken; bit_length writes are taken at any time.

module bitvector_rank_dictionary #(
	parameter int MAX_BITS = brd_pkg::MAX_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_write_en,
	input  logic [brd_pkg::LEN_W-1:0]     cfg_write_data,
	// request channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    operation,
	input  logic [brd_pkg::IDX_W-1:0]     bit_index,
	input  logic                          count_ones,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          bit_value,
	output logic [brd_pkg::LEN_W-1:0]     rank_count,
	output logic                          index_error
);

	localparam int WORD_COUNT = (MAX_BITS + brd_pkg::WORD_BITS - 1) / brd_pkg::WORD_BITS;
	localparam int WAW        = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam logic [WAW-1:0] LAST_WORD = WAW'(WORD_COUNT - 1);
	localparam logic [16:0]    MAX_BITS_W = 17'(MAX_BITS);

	brd_pkg::brd_state_t state_q, state_d;

	// bit_length register
	logic [brd_pkg::LEN_W-1:0] len_q;

	// latched request
	brd_pkg::op_t              op_q;
	logic [brd_pkg::IDX_W-1:0] idx_q;
	logic                      ones_sel_q;
	logic                      err_q;

	// word counter for clearing pass and build, running prefix sum for build
	logic [WAW-1:0]            w_q;
	logic [brd_pkg::LEN_W-1:0] acc_q;

	// values from the execute step
	logic                      val_q;
	logic [brd_pkg::LEN_W-1:0] ones_q;

	// result register
	logic                      out_valid_q;
	logic                      bit_value_q;
	logic [brd_pkg::LEN_W-1:0] rank_count_q;
	logic                      index_error_q;

	// memory and shared unit hookup
	brd_pkg::brd_store_ctrl_t      st_ctrl;
	logic [WAW-1:0]                wr_addr, rd_addr, req_word;
	logic [brd_pkg::WORD_BITS-1:0] word_wdata, word_rdata;
	logic [brd_pkg::LEN_W-1:0]     sum_wdata, sum_rdata;
	logic                          pa_mask_en;
	logic [brd_pkg::LEN_W-1:0]     pa_base, pa_sum;

	logic                      in_fire, out_free, bad_idx;
	brd_pkg::op_t              in_op;
	logic [brd_pkg::LEN_W-1:0] rank_res;

	assign in_op    = brd_pkg::op_t'(operation);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign req_word = WAW'(idx_q[brd_pkg::IDX_W-1:brd_pkg::BIT_POS_W]);

	// index must sit below both the configured length and the storage size
	assign bad_idx = ({1'b0, bit_index} >= len_q) || (17'(bit_index) >= MAX_BITS_W);

	// ones below the index, or zeros as index minus ones
	assign rank_res = ones_sel_q ? ones_q : ({1'b0, idx_q} - ones_q);

	brd_store #(
		.WORD_COUNT(WORD_COUNT),
		.WAW       (WAW)
	) u_store (
		.clk       (clk),
		.ctrl      (st_ctrl),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr),
		.word_wdata(word_wdata),
		.sum_wdata (sum_wdata),
		.word_rdata(word_rdata),
		.sum_rdata (sum_rdata)
	);

	// one popcount/add unit serves both rank and build
	brd_popadd u_popadd (
		.word   (word_rdata),
		.mask_en(pa_mask_en),
		.bit_pos(idx_q[brd_pkg::BIT_POS_W-1:0]),
		.base   (pa_base),
		.sum    (pa_sum)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			brd_pkg::ST_CLEAR: begin
				if (w_q == LAST_WORD) state_d = brd_pkg::ST_IDLE;
			end
			brd_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (in_op == brd_pkg::OP_BUILD) state_d = brd_pkg::ST_BUILD_RD;
					else if (bad_idx)               state_d = brd_pkg::ST_FIN;
					else                            state_d = brd_pkg::ST_READ;
				end
			end
			brd_pkg::ST_READ:     state_d = brd_pkg::ST_EXEC;
			brd_pkg::ST_EXEC:     state_d = brd_pkg::ST_FIN;
			brd_pkg::ST_FIN: begin
				if (out_free) state_d = brd_pkg::ST_IDLE;
			end
			brd_pkg::ST_BUILD_RD: state_d = brd_pkg::ST_BUILD_WR;
			brd_pkg::ST_BUILD_WR: begin
				if (w_q == LAST_WORD) state_d = brd_pkg::ST_FIN;
				else                  state_d = brd_pkg::ST_BUILD_RD;
			end
			default:              state_d = brd_pkg::ST_CLEAR;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready     = 1'b0;
		st_ctrl      = '0;
		wr_addr      = w_q;
		rd_addr      = req_word;
		word_wdata   = word_rdata | (brd_pkg::WORD_BITS'(1) << idx_q[brd_pkg::BIT_POS_W-1:0]);
		sum_wdata    = acc_q;
		pa_mask_en   = 1'b1;
		pa_base      = sum_rdata;
		case (state_q)
			brd_pkg::ST_CLEAR: begin
				st_ctrl.word_we = 1'b1;
				st_ctrl.sum_we  = 1'b1;
				word_wdata      = '0;
				sum_wdata       = '0;
			end
			brd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			brd_pkg::ST_EXEC: begin
				// set writes the word back with the new bit
				wr_addr         = req_word;
				st_ctrl.word_we = (op_q == brd_pkg::OP_SET);
			end
			brd_pkg::ST_BUILD_RD: begin
				rd_addr = w_q;
			end
			brd_pkg::ST_BUILD_WR: begin
				st_ctrl.sum_we = 1'b1;
				pa_mask_en     = 1'b0;
				pa_base        = acc_q;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= brd_pkg::ST_CLEAR;
			len_q       <= brd_pkg::LEN_RESET;
			w_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write_en) len_q <= cfg_write_data;
			case (state_q)
				brd_pkg::ST_CLEAR:    w_q <= w_q + WAW'(1);
				brd_pkg::ST_IDLE:     w_q <= '0;
				brd_pkg::ST_BUILD_WR: w_q <= w_q + WAW'(1);
				default: begin
				end
			endcase
			if (state_q == brd_pkg::ST_FIN && out_free) out_valid_q <= 1'b1;
			else if (out_ready)                         out_valid_q <= 1'b0;
		end
	end

	// request latch, working values and result payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q       <= in_op;
			idx_q      <= bit_index;
			ones_sel_q <= count_ones;
			err_q      <= (in_op != brd_pkg::OP_BUILD) && bad_idx;
			acc_q      <= '0;
		end
		if (state_q == brd_pkg::ST_EXEC) begin
			val_q  <= word_rdata[idx_q[brd_pkg::BIT_POS_W-1:0]];
			ones_q <= pa_sum;
		end
		if (state_q == brd_pkg::ST_BUILD_WR) begin
			acc_q <= pa_sum;
		end
		if (state_q == brd_pkg::ST_FIN && out_free) begin
			bit_value_q   <= !err_q && (op_q == brd_pkg::OP_ACCESS) && val_q;
			rank_count_q  <= (!err_q && op_q == brd_pkg::OP_RANK) ? rank_res : '0;
			index_error_q <= err_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign bit_value   = bit_value_q;
	assign rank_count  = rank_count_q;
	assign index_error = index_error_q;

endmodule

// ----- verif/bitvector_rank_dictionary_test.sv -----
// self-checking testbench for bitvector_rank_dictionary: directed and random requests
// against an in-bench rank dictionary predictor; depends on brd_pkg and the dut sources

`timescale 1ns / 100ps

module bitvector_rank_dictionary_test;

	localparam int WORDS = brd_pkg::MAX_BITS_DEF / brd_pkg::WORD_BITS;

	// one request as the sender holds it; hold_for_drain makes the driver wait
	// until every outstanding answer has come back before presenting it
	typedef struct packed {
		brd_pkg::op_t              op;
		logic [brd_pkg::IDX_W-1:0] idx;
		logic                      want_ones;
		logic                      hold_for_drain;
	} dict_req_t;

	typedef struct packed {
		logic                      bit_value;
		logic [brd_pkg::LEN_W-1:0] rank_count;
		logic                      index_error;
	} dict_answer_t;

	// the request is kept next to its answer so a mismatch can say what was asked
	typedef struct packed {
		dict_req_t    req;
		dict_answer_t ans;
	} dict_outcome_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_write_en = 1'b0;
	logic [brd_pkg::LEN_W-1:0] cfg_write_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [1:0]                operation = '0;
	logic [brd_pkg::IDX_W-1:0] bit_index = '0;
	logic                      count_ones = 1'b0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic                      bit_value;
	logic [brd_pkg::LEN_W-1:0] rank_count;
	logic                      index_error;

	// predictor state: the words, their prefix counts as of the last build, and the length
	logic [brd_pkg::WORD_BITS-1:0] model_words [WORDS];
	logic [brd_pkg::LEN_W-1:0]     model_prefix [WORDS];
	logic [brd_pkg::LEN_W-1:0]     model_len = brd_pkg::LEN_RESET;

	dict_req_t     pending_requests [$];
	dict_outcome_t awaited_answers [$];
	dict_req_t     cur_req;
	bit            req_in_flight = 1'b0;
	bit            steady = 1'b0;
	int            gap_left = 0;
	int            ready_hold = 0;
	int            fail_count = 0;

	bitvector_rank_dictionary dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.bit_index     (bit_index),
		.count_ones    (count_ones),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.bit_value     (bit_value),
		.rank_count    (rank_count),
		.index_error   (index_error)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [5:0] ones_count(logic [brd_pkg::WORD_BITS-1:0] w);
		logic [5:0] n;
		n = '0;
		for (int i = 0; i < brd_pkg::WORD_BITS; i++)
			n += 6'(w[i]);
		return n;
	endfunction

	// applies one request to the predictor state and returns the answer it must give
	function automatic dict_answer_t dict_apply(dict_req_t r);
		dict_answer_t              a;
		logic [brd_pkg::LEN_W-1:0] acc;
		logic [brd_pkg::LEN_W-1:0] below;
		logic [4:0]                w_sel;
		logic [4:0]                b_sel;
		a = '0;
		w_sel = r.idx[brd_pkg::IDX_W-1:brd_pkg::BIT_POS_W];
		b_sel = r.idx[brd_pkg::BIT_POS_W-1:0];
		if (r.op == brd_pkg::OP_BUILD) begin
			// build ignores index and count_ones, never flags
			acc = '0;
			for (int w = 0; w < WORDS; w++) begin
				model_prefix[w] = acc;
				acc += brd_pkg::LEN_W'(ones_count(model_words[w]));
			end
		end else if ({1'b0, r.idx} >= model_len) begin
			// bad index: no state change, only the flag
			a.index_error = 1'b1;
		end else begin
			case (r.op)
				brd_pkg::OP_SET: begin
					model_words[w_sel][b_sel] = 1'b1;
				end
				brd_pkg::OP_ACCESS: begin
					a.bit_value = model_words[w_sel][b_sel];
				end
				brd_pkg::OP_RANK: begin
					// stored prefix may be stale after sets; that is intended
					below = model_prefix[w_sel] + brd_pkg::LEN_W'(
						ones_count(model_words[w_sel] & ((32'd1 << b_sel) - 32'd1)));
					a.rank_count = r.want_ones ? below : {1'b0, r.idx} - below;
				end
				default: begin
				end
			endcase
		end
		return a;
	endfunction

	// idle lengths: mostly none or short, now and then long; none at all when steady
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic dict_req_t make_req(brd_pkg::op_t op, int idx, bit ones, bit drain);
		dict_req_t r;
		r.op = op;
		r.idx = brd_pkg::IDX_W'(idx);
		r.want_ones = ones;
		r.hold_for_drain = drain;
		return r;
	endfunction

	// random request: mostly indices inside the current length, some at word
	// edges, some anywhere so the error path stays busy
	function automatic dict_req_t random_request();
		dict_req_t   r;
		int unsigned span;
		int unsigned pick;
		span = (model_len > brd_pkg::LEN_W'(brd_pkg::MAX_BITS_DEF)) ?
			brd_pkg::MAX_BITS_DEF : int'(model_len);
		pick = $urandom_range(0, 99);
		r.op = pick < 30 ? brd_pkg::OP_SET : pick < 40 ? brd_pkg::OP_BUILD :
			pick < 65 ? brd_pkg::OP_ACCESS : brd_pkg::OP_RANK;
		pick = $urandom_range(0, 99);
		if (pick < 75 && span != 0)
			r.idx = brd_pkg::IDX_W'($urandom_range(0, span - 1));
		else if (pick < 85)
			r.idx = {5'($urandom_range(0, 31)), ($urandom_range(0, 1) != 0) ? 5'd31 : 5'd0};
		else
			r.idx = brd_pkg::IDX_W'($urandom_range(0, 1023));
		r.want_ones = 1'($urandom_range(0, 1));
		r.hold_for_drain = ($urandom_range(0, 199) == 0);
		return r;
	endfunction

	// request driver: predicts at the accepting edge, then refills from the queue
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				awaited_answers.push_back('{req: cur_req, ans: dict_apply(cur_req)});
				req_in_flight = 1'b0;
				gap_left = pick_gap();
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_requests.size() != 0 &&
						!(pending_requests[0].hold_for_drain && awaited_answers.size() != 0)) begin
					cur_req = pending_requests.pop_front();
					req_in_flight = 1'b1;
					in_valid <= 1'b1;
					operation <= cur_req.op;
					bit_index <= cur_req.idx;
					count_ones <= cur_req.want_ones;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: compares every accepted result with the oldest prediction,
	// and stalls the result side at random
	always @(posedge clk) begin
		dict_outcome_t want;
		if (out_valid && out_ready) begin
			if (awaited_answers.size() == 0) begin
				fail_count++;
				$display("%0t: result with none pending: bit_value %0d rank_count %0d index_error %0d",
					$time, bit_value, rank_count, index_error);
			end else begin
				want = awaited_answers.pop_front();
				if (bit_value !== want.ans.bit_value) begin
					fail_count++;
					$display("%0t: op %s idx %0d bit_value expected %0d actual %0d", $time,
						want.req.op.name(), want.req.idx, want.ans.bit_value, bit_value);
				end
				if (rank_count !== want.ans.rank_count) begin
					fail_count++;
					$display("%0t: op %s idx %0d ones %0d rank_count expected %0d actual %0d",
						$time, want.req.op.name(), want.req.idx, want.req.want_ones,
						want.ans.rank_count, rank_count);
				end
				if (index_error !== want.ans.index_error) begin
					fail_count++;
					$display("%0t: op %s idx %0d index_error expected %0d actual %0d", $time,
						want.req.op.name(), want.req.idx, want.ans.index_error, index_error);
				end
			end
		end
		if (ready_hold > 0) begin
			ready_hold--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			ready_hold = pick_gap();
		end
	end

	// waits until nothing is queued, nothing is on the port and nothing is owed
	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_requests.size() != 0 || req_in_flight || awaited_answers.size() != 0);
	endtask

	task automatic write_length(input logic [brd_pkg::LEN_W-1:0] len);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_write_data <= len;
		model_len = len;
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	initial begin
		int unsigned lens [8];
		foreach (model_words[w]) begin
			model_words[w] = '0;
			model_prefix[w] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed, full length from reset: empty store, word edges, stale ranks
		pending_requests.push_back(make_req(brd_pkg::OP_ACCESS, 0, 0, 0));
		pending_requests.push_back(make_req(brd_pkg::OP_RANK, 1023, 1, 0));
		pending_requests.push_back(make_req(brd_pkg::OP_RANK, 1023, 0, 0));
		pending_requests.push_back(make_req(brd_pkg::OP_SET, 0, 0, 0));
		pending_requests.push_back(make_req(brd_pkg::OP_SET, 31, 1, 0));
		pending_requests.push_back(make_req(brd_pkg::OP_SET, 32, 0, 0));
		pending_requests.push_back(make_req(brd_pkg::OP_SET, 1023, 1, 0));
		pending_requests.push_back(make_req(brd_pkg::OP_ACCESS, 1023, 0, 0));
		pending_requests.push_back(make_req(brd_pkg::OP_ACCESS, 1, 0, 0));
		// rank before any build sees all-zero prefix counts
		pending_requests.push_back(make_req(brd_pkg::OP_RANK, 1023, 1, 0));
		// build with junk in the unused fields
		pending_requests.push_back(make_req(brd_pkg::OP_BUILD, 1023, 1, 0));
		pending_requests.push_back(make_req(brd_pkg::OP_RANK, 1023, 1, 0));
		pending_requests.push_back(make_req(brd_pkg::OP_RANK, 33, 0, 0));
		pending_requests.push_back(make_req(brd_pkg::OP_RANK, 0, 1, 0));
		// sender holds off here until every answer is back
		pending_requests.push_back(make_req(brd_pkg::OP_SET, 600, 0, 1));
		pending_requests.push_back(make_req(brd_pkg::OP_RANK, 1000, 1, 0));
		pending_requests.push_back(make_req(brd_pkg::OP_BUILD, 0, 0, 0));
		pending_requests.push_back(make_req(brd_pkg::OP_RANK, 1000, 1, 0));

		// zero length: every indexed request is bad, build still fine
		wait_drained();
		write_length('0);
		pending_requests.push_back(make_req(brd_pkg::OP_ACCESS, 0, 0, 0));
		pending_requests.push_back(make_req(brd_pkg::OP_SET, 5, 0, 0));
		pending_requests.push_back(make_req(brd_pkg::OP_RANK, 0, 1, 0));
		pending_requests.push_back(make_req(brd_pkg::OP_BUILD, 0, 0, 0));

		// one bit in use
		wait_drained();
		write_length(brd_pkg::LEN_W'(1));
		pending_requests.push_back(make_req(brd_pkg::OP_ACCESS, 0, 0, 0));
		pending_requests.push_back(make_req(brd_pkg::OP_SET, 0, 1, 0));
		pending_requests.push_back(make_req(brd_pkg::OP_ACCESS, 1, 0, 0));
		pending_requests.push_back(make_req(brd_pkg::OP_RANK, 0, 0, 0));

		// length beyond the store acts as the full store
		wait_drained();
		write_length('1);
		pending_requests.push_back(make_req(brd_pkg::OP_RANK, 1023, 0, 0));

		// random phases over a spread of lengths; two of them run with no idling
		lens = '{1024, 1, 2047, 0, 64, 1000, 33, 0};
		lens[7] = $urandom_range(2, 1023);
		for (int p = 0; p < 8; p++) begin
			wait_drained();
			write_length(brd_pkg::LEN_W'(lens[p]));
			steady = (p == 2 || p == 5);
			for (int k = 0; k < 85; k++)
				pending_requests.push_back(random_request());
		end

		wait_drained();
		// room for a stray result after the last one
		repeat (80) @(posedge clk);
		if (fail_count == 0)
			$display("PASS bitvector_rank_dictionary");
		else
			$display("FAIL bitvector_rank_dictionary");
		$finish;
	end

	// run limit
	initial begin
		#5000000;
		$display("FAIL bitvector_rank_dictionary");
		$finish;
	end

endmodule
